### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define LBB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LBB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lbb_pkg.sv
`default_nettype none

package lbb_pkg;

  // Window geometry.
  localparam int MAX_RADIUS = 31;
  localparam int LINE_MAX = 4096;
  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 2;
  localparam int RADIUS_CNT = MAX_RADIUS + 1;

  // Field and datapath widths.
  localparam int RAD_W = 5;
  localparam int CH_W = 8;
  localparam int NUM_LANES = 4;
  localparam int DATA_W = NUM_LANES * CH_W;
  localparam int POS_W = $clog2(LINE_MAX);
  localparam int ADDR_W = $clog2(WIN_DEPTH);
  localparam int FACTOR_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUM_W = $clog2((2 * MAX_RADIUS + 1) * ((1 << CH_W) - 1) + 1);

  // Reciprocal scaling: exact floor division for every sum and window width.
  localparam int RECIP_SHIFT = SUM_W + $clog2(2 * MAX_RADIUS + 1);
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W = SUM_W + RECIP_W;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_OUT
  } lbb_state_t;

  // Per-lane controls driven by the sequencer.
  typedef struct packed {
    logic                load_sum;
    logic                base_zero;
    logic [FACTOR_W-1:0] factor;
    logic                sub_en;
    logic                sub_first;
    logic                load_prod;
  } lbb_lane_ctrl_t;

endpackage

`default_nettype wire

### rtl/lbb_ram.sv
`default_nettype none

module lbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/lbb_lane.sv
`default_nettype none

module lbb_lane (
  input  logic                            clk,
  input  lbb_pkg::lbb_lane_ctrl_t         ctrl,
  input  logic [lbb_pkg::CH_W-1:0]        px,
  input  logic [lbb_pkg::CH_W-1:0]        first_ch,
  input  logic [lbb_pkg::CH_W-1:0]        rd_ch,
  input  logic [lbb_pkg::RECIP_W-1:0]     recip,
  output logic [lbb_pkg::CH_W-1:0]        quot
);

  logic [lbb_pkg::SUM_W-1:0]                    sum;
  logic [lbb_pkg::SUM_W-1:0]                    sum_next;
  logic [lbb_pkg::FACTOR_W+lbb_pkg::CH_W-1:0]   scaled;
  logic [lbb_pkg::SUM_W:0]                      acc_sum;
  logic [lbb_pkg::SUM_W:0]                      sub_val;
  logic [lbb_pkg::PROD_W-1:0]                   prod;
  logic [lbb_pkg::PROD_W-1:0]                   prod_next;

  // Running window sum: add the scaled entering pixel, drop the leaving one.
  always_comb begin
    scaled  = ctrl.factor * px;
    acc_sum = (ctrl.base_zero ? '0 : (lbb_pkg::SUM_W + 1)'(sum))
              + (lbb_pkg::SUM_W + 1)'(scaled);
    if (!ctrl.sub_en) begin
      sub_val = '0;
    end else if (ctrl.sub_first) begin
      sub_val = (lbb_pkg::SUM_W + 1)'(first_ch);
    end else begin
      sub_val = (lbb_pkg::SUM_W + 1)'(rd_ch);
    end
    sum_next = lbb_pkg::SUM_W'(acc_sum - sub_val);
  end

  // Divide by the window width as a multiply by its scaled reciprocal.
  assign prod_next = sum * recip;

  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      sum <= sum_next;
    end
    if (ctrl.load_prod) begin
      prod <= prod_next;
    end
  end

  assign quot = prod[lbb_pkg::RECIP_SHIFT +: lbb_pkg::CH_W];

endmodule

`default_nettype wire

### rtl/lbb_merge.sv
`default_nettype none

module lbb_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  logic [lbb_pkg::NUM_LANES-1:0][lbb_pkg::CH_W-1:0] quot,
  input  logic                                          last,
  input  logic                                          m_axis_tready,
  output logic                                          m_axis_tvalid,
  output logic [lbb_pkg::DATA_W-1:0]                    m_axis_tdata,
  output logic                                          m_axis_tlast,
  output logic                                          free
);

  // The output register may take a new pixel when empty or being drained.
  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Pack the lane results, first lane in the lowest byte.
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= quot;
      m_axis_tlast <= last;
    end
  end

endmodule

`default_nettype wire

### rtl/line_box_blur.sv
// Channel   Handshake                     Payload
// cfg       cfg_valid / cfg_ready         cfg_data: radius
// s_axis    s_axis_tvalid / s_axis_tready tdata: alpha, red, green, blue; tlast: line end
// m_axis    m_axis_tvalid / m_axis_tready tdata: alpha, red, green, blue; tlast: last
//
// A pixel that releases an output passes through accept, window sum update,
// reciprocal multiply and output register load. A pixel before position radius
// that does not end the line releases nothing and passes through accept and
// window sum update only. On the last pixel of a line each further pending output
// passes through the multiply stage and the output register load.
// A stalled output register holds the sequencer in its output state.
// Reset is synchronous, closes both request channels while high and needs no
// clearing pass; the window memory is never read before it is written within the
// current line.
`default_nettype none

module line_box_blur (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lbb_pkg::RAD_W-1:0]    cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // alpha_in [7:0], red_in [15:8], green_in [23:16], blue_in [31:24]
  input  logic [lbb_pkg::DATA_W-1:0]   s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // alpha_out [7:0], red_out [15:8], green_out [23:16], blue_out [31:24]
  output logic [lbb_pkg::DATA_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast
);

  lbb_pkg::lbb_state_t       state, state_next;
  logic [lbb_pkg::RAD_W-1:0] radius, line_rad, rad_sat, r_minus_p;
  logic [lbb_pkg::RECIP_W-1:0] line_recip;
  logic [lbb_pkg::RECIP_W-1:0] recip_tab [lbb_pkg::RADIUS_CNT];
  logic [lbb_pkg::POS_W-1:0] pos, out_pos;
  logic [lbb_pkg::DATA_W-1:0] pix, first_pix, rd_data;
  logic [lbb_pkg::ADDR_W-1:0] rd_addr;
  logic [lbb_pkg::FACTOR_W-1:0] factor;
  logic [lbb_pkg::NUM_LANES-1:0][lbb_pkg::CH_W-1:0] quot;
  lbb_pkg::lbb_lane_ctrl_t   lane_ctrl;
  logic line_end_r, in_acc, out_free, out_load, out_last, flush_more, emit;
  logic p_is0, p_lt_r, p_le_2r;

  // Configuration register, ready whenever reset is low.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= lbb_pkg::RAD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  assign rad_sat = (radius > lbb_pkg::RAD_W'(lbb_pkg::MAX_RADIUS))
                   ? lbb_pkg::RAD_W'(lbb_pkg::MAX_RADIUS) : radius;

  // Reciprocal table, ceil(2^shift / (2r+1)) for every radius.
  for (genvar g = 0; g < lbb_pkg::RADIUS_CNT; g++) begin : g_recip
    localparam int Div = 2 * g + 1;
    localparam int Recip = ((1 << lbb_pkg::RECIP_SHIFT) + Div - 1) / Div;
    assign recip_tab[g] = lbb_pkg::RECIP_W'(Recip);
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Position tests used by the sequencer.
  assign p_is0      = (pos == '0);
  assign p_lt_r     = (pos < lbb_pkg::POS_W'(line_rad));
  assign p_le_2r    = (pos <= lbb_pkg::POS_W'({line_rad, 1'b0}));
  assign r_minus_p  = line_rad - pos[lbb_pkg::RAD_W-1:0];
  assign emit       = !p_lt_r || line_end_r;
  assign flush_more = line_end_r && (out_pos != pos);
  assign out_last   = line_end_r && (out_pos == pos);

  // Weight of the entering pixel: the first pixel covers the left edge, and the
  // last pixel of a short line also covers the missing right side.
  always_comb begin
    factor = p_is0 ? (lbb_pkg::FACTOR_W'(line_rad) + lbb_pkg::FACTOR_W'(1))
                   : lbb_pkg::FACTOR_W'(1);
    if (line_end_r && p_lt_r) begin
      factor = factor + lbb_pkg::FACTOR_W'(r_minus_p);
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      lbb_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = lbb_pkg::ST_ACC;
        end
      end
      lbb_pkg::ST_ACC: begin
        state_next = emit ? lbb_pkg::ST_MUL : lbb_pkg::ST_IDLE;
      end
      lbb_pkg::ST_MUL: begin
        state_next = lbb_pkg::ST_OUT;
      end
      lbb_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = flush_more ? lbb_pkg::ST_MUL : lbb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbb_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic: handshake, memory read address and lane controls.
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    lane_ctrl     = '0;
    rd_addr       = lbb_pkg::ADDR_W'(out_pos - lbb_pkg::POS_W'(line_rad));
    case (state)
      lbb_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        // Pixel leaving the window when the new one enters.
        rd_addr = lbb_pkg::ADDR_W'(pos - lbb_pkg::POS_W'({line_rad, 1'b0})
                                   - lbb_pkg::POS_W'(1));
      end
      lbb_pkg::ST_ACC: begin
        lane_ctrl.load_sum  = 1'b1;
        lane_ctrl.base_zero = p_is0;
        lane_ctrl.factor    = factor;
        lane_ctrl.sub_en    = !p_is0 && !p_lt_r && (pos != lbb_pkg::POS_W'(line_rad));
        lane_ctrl.sub_first = p_le_2r;
      end
      lbb_pkg::ST_MUL: begin
        lane_ctrl.load_prod = 1'b1;
      end
      lbb_pkg::ST_OUT: begin
        out_load = out_free;
        if (out_free && flush_more) begin
          // Flush step: last pixel enters, left edge pixel leaves.
          lane_ctrl.load_sum  = 1'b1;
          lane_ctrl.factor    = lbb_pkg::FACTOR_W'(1);
          lane_ctrl.sub_en    = 1'b1;
          lane_ctrl.sub_first = (out_pos < lbb_pkg::POS_W'(line_rad));
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Sequencer state and line positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lbb_pkg::ST_IDLE;
      pos     <= '0;
      out_pos <= '0;
    end else begin
      state <= state_next;
      if (state == lbb_pkg::ST_ACC && !emit) begin
        pos <= pos + lbb_pkg::POS_W'(1);
      end
      if (out_load) begin
        if (flush_more) begin
          out_pos <= out_pos + lbb_pkg::POS_W'(1);
        end else if (line_end_r) begin
          pos     <= '0;
          out_pos <= '0;
        end else begin
          pos     <= pos + lbb_pkg::POS_W'(1);
          out_pos <= out_pos + lbb_pkg::POS_W'(1);
        end
      end
    end
  end

  // Line parameters are taken at the first pixel of each line.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_rad <= lbb_pkg::RAD_W'(1);
    end else if (in_acc && p_is0) begin
      line_rad <= rad_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix        <= s_axis_tdata;
      line_end_r <= s_axis_tlast || (pos == lbb_pkg::POS_W'(lbb_pkg::LINE_MAX - 1));
      if (p_is0) begin
        first_pix  <= s_axis_tdata;
        line_recip <= recip_tab[rad_sat];
      end
    end
  end

  // Recent pixels of the line, addressed by position modulo the depth.
  lbb_ram #(
    .WIDTH (lbb_pkg::DATA_W),
    .DEPTH (lbb_pkg::WIN_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (pos[lbb_pkg::ADDR_W-1:0]),
    .wr_data (s_axis_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // One lane per channel: alpha, red, green and blue.
  for (genvar g = 0; g < lbb_pkg::NUM_LANES; g++) begin : g_lane
    lbb_lane u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl),
      .px       (pix[g*lbb_pkg::CH_W +: lbb_pkg::CH_W]),
      .first_ch (first_pix[g*lbb_pkg::CH_W +: lbb_pkg::CH_W]),
      .rd_ch    (rd_data[g*lbb_pkg::CH_W +: lbb_pkg::CH_W]),
      .recip    (line_recip),
      .quot     (quot[g])
    );
  end

  lbb_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (out_load),
    .quot          (quot),
    .last          (out_last),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .free          (out_free)
  );

endmodule

`default_nettype wire

### rtl/lbb_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lbb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [lbb_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast
);

  // A stalled result keeps its value until taken.
  `LBB_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

  // Reset empties the output register.
  `LBB_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // Only one pixel is worked on at a time.
  `LBB_ASSERT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

  // The last pixel of a line holds the input closed while its first output is formed.
  `LBB_ASSERT(a_end_busy, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready, "line end not flushed")

  // A new result only appears out of the output state.
  `LBB_ASSERT(a_out_src, clk, rst, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result loaded while idle")

endmodule

bind line_box_blur lbb_checker u_checker (.*);

`default_nettype wire
